@@ hdl/edge_count_trigger_qualifier_defines.svh @@
// Assertion macros for the edge count trigger qualifier.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef EDGE_COUNT_TRIGGER_QUALIFIER_DEFINES_SVH
`define EDGE_COUNT_TRIGGER_QUALIFIER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ECTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ectq check failed");
// Next-cycle implication, checked outside reset.
`define ECTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ectq check failed");
`else
`define ECTQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ECTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ectq_pkg.sv @@
// Shared types and constants for the edge count trigger qualifier.
// No dependencies.
`timescale 1ns / 1ps

package ectq_pkg;

  localparam int ECTQ_TIME_WIDTH = 32;

  localparam int CMD_W  = 2;
  localparam int TIME_W = 32;
  localparam int BYTE_W = 8;
  localparam int MS_W   = 16;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 16;

  localparam logic [BYTE_W-1:0] PORT_MASK_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] TRIG_MODE_RST    = 8'd0;
  localparam logic [MS_W-1:0]   IDLE_MS_RST      = 16'd2000;
  localparam logic [MS_W-1:0]   UNLOCK_DELAY_RST = 16'd1000;

  localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_UNLOCK = 2'd2
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PORT_MASK    = 2'd0,
    REG_TRIGGER_MODE = 2'd1,
    REG_IDLE_MS      = 2'd2,
    REG_UNLOCK_DELAY = 2'd3
  } reg_idx_t;

endpackage

@@ hdl/edge_count_trigger_qualifier.sv @@
// Edge count trigger qualifier: input register, one pass of qualify logic, result register.
// Depends on ectq_pkg and edge_count_trigger_qualifier_defines.svh.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | command, time_ms, port_value
//  out_    | output    | out_valid/out_stall| triggered, changing, locked
//  cfg_    | input     | cfg_valid/cfg_ready| index, data (ready always high)
//
// One item per cycle while out_stall is low; an item passes the input register, then the result register.
// The input register doubles as a skid stage, so an item is taken while a result waits.
// Synchronous active-low reset clears state, configuration and valid flags; payload registers are not reset.
// A stalled result holds the qualify stage; the input register then holds one item.
`timescale 1ns / 1ps
`include "edge_count_trigger_qualifier_defines.svh"

module edge_count_trigger_qualifier
  import ectq_pkg::*;
#(
  parameter int TIME_WIDTH = ECTQ_TIME_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [TIME_W-1:0] in_time_ms,
  input  logic [BYTE_W-1:0] in_port_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_triggered,
  output logic              out_changing,
  output logic              out_locked,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // configuration
  logic [BYTE_W-1:0] port_mask_r;
  logic [BYTE_W-1:0] trig_mode_r;
  logic [MS_W-1:0]   idle_ms_r;
  logic [MS_W-1:0]   unlock_delay_r;

  // input register
  logic              in_valid_r;
  logic [CMD_W-1:0]  in_cmd_r;
  logic [TIME_W-1:0] in_time_r;
  logic [BYTE_W-1:0] in_port_r;

  // qualifier state
  logic                  last_level_r,  last_level_nxt;
  logic [BYTE_W-1:0]     edge_count_r,  edge_count_nxt;
  logic [TIME_WIDTH-1:0] last_edge_r,   last_edge_nxt;
  logic                  lock_r,        lock_nxt;
  logic                  pending_r,     pending_nxt;
  logic [TIME_WIDTH-1:0] deadline_r,    deadline_nxt;
  logic                  changing_r,    changing_nxt;
  logic                  fired;

  // result register
  logic out_valid_r;
  logic out_trig_r;
  logic out_chg_r;
  logic out_lock_r;

  logic                  advance;
  logic [TIME_WIDTH-1:0] now;
  logic                  level;
  logic [TIME_WIDTH:0]   dl_sum;
  logic [TIME_WIDTH-1:0] dl_sat;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  idle_hit;
  logic [BYTE_W-1:0]     count_inc;
  logic [BYTE_W-1:0]     target;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  generate
    if (TIME_WIDTH > TIME_W) begin : g_time_ext
      assign now = {{(TIME_WIDTH-TIME_W){1'b0}}, in_time_r};
    end else begin : g_time_cut
      assign now = in_time_r[TIME_WIDTH-1:0];
    end
  endgenerate

  assign level  = |(in_port_r & port_mask_r);
  assign dl_sum = {1'b0, now} + {{(TIME_WIDTH+1-MS_W){1'b0}}, unlock_delay_r};
  // saturate the deadline at the largest time value
  assign dl_sat = dl_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : dl_sum[TIME_WIDTH-1:0];
  assign elapsed  = now - last_edge_r;
  assign idle_hit = (now >= last_edge_r)
                    && (elapsed > {{(TIME_WIDTH-MS_W){1'b0}}, idle_ms_r});
  assign count_inc = edge_count_r + 8'd1;

  always_comb begin
    if (trig_mode_r == 8'd0) begin
      target = 8'd1;
    end else if (trig_mode_r == 8'd1) begin
      target = 8'd2;
    end else begin
      target = trig_mode_r;
    end
  end

  always_comb begin
    last_level_nxt = last_level_r;
    edge_count_nxt = edge_count_r;
    last_edge_nxt  = last_edge_r;
    lock_nxt       = lock_r;
    pending_nxt    = pending_r;
    deadline_nxt   = deadline_r;
    changing_nxt   = changing_r;
    fired          = 1'b0;
    unique case (in_cmd_r)
      CMD_SAMPLE: begin
        priority if (pending_r && (deadline_r < now)) begin
          // release the lock and only reload the stored level
          lock_nxt       = 1'b0;
          pending_nxt    = 1'b0;
          deadline_nxt   = '0;
          last_level_nxt = level;
        end else if (lock_r) begin
          // muted: hold everything
        end else if (last_level_r && !level) begin
          last_level_nxt = 1'b0;
          last_edge_nxt  = now;
          if (edge_count_r != COUNT_MAX) begin
            edge_count_nxt = count_inc;
            if (count_inc == 8'd1) begin
              changing_nxt = 1'b1;
            end
            if (count_inc == target) begin
              changing_nxt = 1'b0;
              fired        = 1'b1;
            end
          end
        end else begin
          last_level_nxt = level;
          if (idle_hit) begin
            edge_count_nxt = '0;
            changing_nxt   = 1'b0;
          end
        end
      end
      CMD_LOCK: begin
        lock_nxt = 1'b1;
      end
      CMD_UNLOCK: begin
        deadline_nxt = dl_sat;
        pending_nxt  = 1'b1;
      end
      default: begin
        // unused command: state unchanged, result still produced
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_mask_r    <= PORT_MASK_RST;
      trig_mode_r    <= TRIG_MODE_RST;
      idle_ms_r      <= IDLE_MS_RST;
      unlock_delay_r <= UNLOCK_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PORT_MASK:    port_mask_r    <= cfg_data[BYTE_W-1:0];
        REG_TRIGGER_MODE: trig_mode_r    <= cfg_data[BYTE_W-1:0];
        REG_IDLE_MS:      idle_ms_r      <= cfg_data;
        REG_UNLOCK_DELAY: unlock_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!in_valid_r || advance) && in_valid) begin
      in_cmd_r  <= in_command;
      in_time_r <= in_time_ms;
      in_port_r <= in_port_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      edge_count_r <= '0;
      last_edge_r  <= '0;
      lock_r       <= 1'b0;
      pending_r    <= 1'b0;
      deadline_r   <= '0;
      changing_r   <= 1'b0;
    end else if (advance) begin
      last_level_r <= last_level_nxt;
      edge_count_r <= edge_count_nxt;
      last_edge_r  <= last_edge_nxt;
      lock_r       <= lock_nxt;
      pending_r    <= pending_nxt;
      deadline_r   <= deadline_nxt;
      changing_r   <= changing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_trig_r <= fired;
      out_chg_r  <= changing_nxt;
      out_lock_r <= lock_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_triggered = out_trig_r;
  assign out_changing  = out_chg_r;
  assign out_locked    = out_lock_r;

  `ECTQ_ASSERT_SAME(a_fire_clears_changing, clk, rst_n, out_valid_r && out_trig_r, !out_chg_r)
  `ECTQ_ASSERT_SAME(a_fire_unlocked, clk, rst_n, out_valid_r && out_trig_r, !out_lock_r)
  `ECTQ_ASSERT_SAME(a_idle_count_quiet, clk, rst_n, edge_count_r == '0, !changing_r)
  `ECTQ_ASSERT_SAME(a_deadline_cleared, clk, rst_n, !pending_r, deadline_r == '0)
  `ECTQ_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(edge_count_r) && $stable(lock_r))

endmodule
